// ===== rtl/atrm_pkg.sv =====
// Shared types, constants and codes for the AT response matcher.
// Used by the top level, controller, datapath and checker; no dependencies.
`default_nettype none
package atrm_pkg;

  localparam int LINE_LEN  = 64;
  localparam int NUM_RSP   = 4;
  localparam int NUM_ERR   = 4;
  localparam int NUM_SLOTS = NUM_RSP + NUM_ERR;
  localparam int LINE_AW   = $clog2(LINE_LEN);
  localparam int SLOT_W    = 3;
  localparam int PAT_AW    = SLOT_W + LINE_AW;
  localparam int PAT_DEPTH = NUM_SLOTS * LINE_LEN;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 4;
  localparam int SCAN_W    = SLOT_W + 1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // item commands
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_BYTE   = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_RESEND = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // result events
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_MATCH   = 3'd1;
  localparam logic [2:0] EV_CAPTURE = 3'd2;
  localparam logic [2:0] EV_ERROR   = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;
  localparam logic [2:0] EV_SEND    = 3'd5;
  localparam logic [2:0] EV_READ    = 3'd6;

  // command status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_REPEAT = 2'd2;
  localparam logic [1:0] ST_FAIL   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_CRITICAL = 2'd1;
  localparam logic [1:0] CFG_VARIABLE = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic [2:0]  slot;
    logic [5:0]  byte_index;
    logic [6:0]  pattern_len;
    logic [15:0] tick_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] match_index;
    logic [3:0] line_count;
    logic       critical_flag;
    logic       timeout_flag;
    logic [7:0] read_byte;
    logic [6:0] read_len;
    logic       busy_res;
    logic       line_overflow;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_init;
    logic skip_slot;
    logic issue_cmp;
    logic step_idx;
    logic set_found;
    logic copy_rd;
    logic copy_wr;
    logic finish;
    logic read_emit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_read;
    logic line_end_act;
    logic var_mode;
    logic scan_done;
    logic len_eq;
    logic bytes_eq;
    logic last_idx;
  } dps_t;

endpackage
`default_nettype wire

// ===== rtl/at_response_matcher_unit.sv =====
// AT response matcher: start, tick, load and repeat words finish at the accept,
// with any result in the cycle after; a read waits for the pattern RAM read.
// A line end skips each slot of another length and compares the line byte by
// byte with the rest, a registered RAM read before each compare, or in capture
// mode copies the line into a slot. Synchronous active-low reset clears status to
// failed, the elapsed, line and capture counters and slot lengths; RAM contents are undefined until written.
`default_nettype none
module at_response_matcher_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire atrm_pkg::in_word_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      atrm_pkg::out_word_t out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  atrm_pkg::ctl_t ctl;
  atrm_pkg::dps_t st;

  atrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  atrm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .st        (st)
  );

endmodule
`default_nettype wire

// ===== rtl/atrm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module atrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, data held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/atrm_ctrl.sv =====
// Sequencer of the AT response matcher: item acceptance, slot scan,
// capture copy and result hand-off. Depends on atrm_pkg.
`default_nettype none
module atrm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire atrm_pkg::dps_t st,
  output      atrm_pkg::ctl_t ctl
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CMP_SEL = 7'b0000010,
    S_CMP_CHK = 7'b0000100,
    S_COPY_RD = 7'b0001000,
    S_COPY_WR = 7'b0010000,
    S_FIN     = 7'b0100000,
    S_RD      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && st.out_free;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.accept = 1'b1;
          if (st.is_read) begin
            state_nxt = S_RD;
          end else if (st.line_end_act) begin
            ctl.scan_init = 1'b1;
            state_nxt = st.var_mode ? S_COPY_RD : S_CMP_SEL;
          end
        end
      end
      S_CMP_SEL: begin
        if (st.scan_done) begin
          state_nxt = S_FIN;
        end else if (!st.len_eq) begin
          ctl.skip_slot = 1'b1;
        end else begin
          ctl.issue_cmp = 1'b1;
          state_nxt = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (!st.bytes_eq) begin
          ctl.skip_slot = 1'b1;
          state_nxt = S_CMP_SEL;
        end else if (st.last_idx) begin
          ctl.set_found = 1'b1;
          state_nxt = S_FIN;
        end else begin
          ctl.step_idx = 1'b1;
          state_nxt = S_CMP_SEL;
        end
      end
      S_COPY_RD: begin
        ctl.copy_rd = 1'b1;
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        ctl.copy_wr = 1'b1;
        if (st.last_idx) begin
          state_nxt = S_FIN;
        end else begin
          ctl.step_idx = 1'b1;
          state_nxt = S_COPY_RD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          ctl.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        if (st.out_free) begin
          ctl.read_emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/atrm_dp.sv =====
// Datapath of the AT response matcher: registers, line and pattern RAMs,
// scan counters and the result register. Depends on atrm_pkg, atrm_ram.
`default_nettype none
module atrm_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atrm_pkg::in_word_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      atrm_pkg::out_word_t out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire atrm_pkg::ctl_t      ctl,
  output      atrm_pkg::dps_t      st
);

  localparam int LW = atrm_pkg::LEN_W;

  logic [31:0] timeout_r, timeout_nxt;
  logic        crit_r, crit_nxt;
  logic        var_r, var_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [LW-1:0] line_len_r, line_len_nxt;
  logic [LW-1:0] slot_len_r [atrm_pkg::NUM_SLOTS];
  logic [LW-1:0] slot_len_nxt [atrm_pkg::NUM_SLOTS];
  logic [atrm_pkg::CNT_W-1:0] cap_r, cap_nxt;
  logic        ovf_r, ovf_nxt;
  logic        line_ovf_r, line_ovf_nxt;
  logic [atrm_pkg::SCAN_W-1:0] slot_r, slot_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic        found_r, found_nxt;
  logic        out_valid_r, out_valid_nxt;
  atrm_pkg::out_word_t out_r, out_nxt;

  // RAM ports
  logic        line_we, line_re;
  logic [atrm_pkg::LINE_AW-1:0] line_waddr;
  logic [7:0]  line_q;
  logic        pat_we, pat_re;
  logic [atrm_pkg::PAT_AW-1:0] pat_waddr, pat_raddr;
  logic [7:0]  pat_wdata, pat_q;

  // helpers
  logic        ended, room, acc_byte;
  logic [32:0] tick_sum;
  logic [31:0] tick_sat;
  logic [LW-1:0] cur_slot_len;
  logic [atrm_pkg::SLOT_W-1:0] cap_slot;
  logic [atrm_pkg::CNT_W-1:0]  cap_inc;
  atrm_pkg::out_word_t ev;

  assign ended    = (prev_r == atrm_pkg::CH_CR) && (in_data.data_byte == atrm_pkg::CH_LF);
  assign room     = line_len_r < LW'(atrm_pkg::LINE_LEN);
  assign acc_byte = ctl.accept && (in_data.command == atrm_pkg::CMD_BYTE);
  assign tick_sum = {1'b0, elapsed_r} + {17'b0, in_data.tick_count};
  assign tick_sat = tick_sum[32] ? '1 : tick_sum[31:0];
  assign cur_slot_len = slot_len_r[slot_r[atrm_pkg::SLOT_W-1:0]];
  assign cap_slot = cap_r[atrm_pkg::SLOT_W-1:0];
  assign cap_inc  = cap_r + 1'b1;

  // line store: written on received bytes, read by scan and copy
  assign line_we    = acc_byte && room;
  assign line_waddr = line_len_r[atrm_pkg::LINE_AW-1:0];
  assign line_re    = ctl.issue_cmp || ctl.copy_rd;

  atrm_ram #(.WIDTH(8), .DEPTH(atrm_pkg::LINE_LEN)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (in_data.data_byte),
    .re    (line_re),
    .raddr (idx_r[atrm_pkg::LINE_AW-1:0]),
    .rdata (line_q)
  );

  // pattern store: loads and captures write, scan and reads read
  assign pat_we = ctl.copy_wr ||
                  (ctl.accept && (in_data.command == atrm_pkg::CMD_LOAD) &&
                   ({1'b0, in_data.slot} < atrm_pkg::SCAN_W'(atrm_pkg::NUM_SLOTS)) &&
                   ({1'b0, in_data.byte_index} < LW'(atrm_pkg::LINE_LEN)));
  assign pat_waddr = ctl.copy_wr ? {cap_slot, idx_r[atrm_pkg::LINE_AW-1:0]}
                                 : {in_data.slot, in_data.byte_index};
  assign pat_wdata = ctl.copy_wr ? line_q : in_data.data_byte;
  assign pat_re    = ctl.issue_cmp || (ctl.accept && (in_data.command == atrm_pkg::CMD_READ));
  assign pat_raddr = ctl.issue_cmp ? {slot_r[atrm_pkg::SLOT_W-1:0],
                                      idx_r[atrm_pkg::LINE_AW-1:0]}
                                   : {in_data.slot, in_data.byte_index};

  atrm_ram #(.WIDTH(8), .DEPTH(atrm_pkg::PAT_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (pat_re),
    .raddr (pat_raddr),
    .rdata (pat_q)
  );

  // status to controller
  always_comb begin
    st.out_free     = !out_valid_r || out_ready;
    st.is_read      = in_data.command == atrm_pkg::CMD_READ;
    st.line_end_act = (in_data.command == atrm_pkg::CMD_BYTE) && ended &&
                      ((status_r == atrm_pkg::ST_RUN) || (status_r == atrm_pkg::ST_REPEAT));
    st.var_mode     = var_r;
    st.scan_done    = slot_r == atrm_pkg::SCAN_W'(atrm_pkg::NUM_SLOTS);
    st.len_eq       = cur_slot_len == line_len_r;
    st.bytes_eq     = line_q == pat_q;
    st.last_idx     = (idx_r + 1'b1) >= line_len_r;
  end

  // next-state logic
  always_comb begin
    timeout_nxt   = timeout_r;
    crit_nxt      = crit_r;
    var_nxt       = var_r;
    status_nxt    = status_r;
    busy_nxt      = busy_r;
    elapsed_nxt   = elapsed_r;
    prev_nxt      = prev_r;
    line_len_nxt  = line_len_r;
    slot_len_nxt  = slot_len_r;
    cap_nxt       = cap_r;
    ovf_nxt       = ovf_r;
    line_ovf_nxt  = line_ovf_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ev            = '0;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        atrm_pkg::CFG_TIMEOUT:  timeout_nxt = cfg_data;
        atrm_pkg::CFG_CRITICAL: crit_nxt    = cfg_data[0];
        atrm_pkg::CFG_VARIABLE: var_nxt     = cfg_data[0];
        default: ;
      endcase
    end

    // item taken in
    if (ctl.accept) begin
      unique case (in_data.command)
        atrm_pkg::CMD_LOAD: begin
          if ({1'b0, in_data.slot} < atrm_pkg::SCAN_W'(atrm_pkg::NUM_SLOTS)) begin
            slot_len_nxt[in_data.slot] =
              (in_data.pattern_len > LW'(atrm_pkg::LINE_LEN)) ? LW'(atrm_pkg::LINE_LEN)
                                                              : in_data.pattern_len;
          end
        end
        atrm_pkg::CMD_START: begin
          elapsed_nxt  = '0;
          status_nxt   = atrm_pkg::ST_RUN;
          busy_nxt     = 1'b1;
          ev.event_res = atrm_pkg::EV_SEND;
          ev.busy_res  = 1'b1;
          out_nxt       = ev;
          out_valid_nxt = 1'b1;
        end
        atrm_pkg::CMD_BYTE: begin
          prev_nxt = in_data.data_byte;
          if (room) begin
            line_len_nxt = line_len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (ended) begin
            if (st.line_end_act) begin
              line_ovf_nxt = ovf_r || !room;
            end else begin
              line_len_nxt = '0;
              ovf_nxt      = 1'b0;
            end
          end
        end
        atrm_pkg::CMD_TICK: begin
          elapsed_nxt = tick_sat;
          if (status_r == atrm_pkg::ST_REPEAT) begin
            status_nxt    = atrm_pkg::ST_RUN;
            ev.event_res  = atrm_pkg::EV_SEND;
            ev.busy_res   = busy_r;
            out_nxt       = ev;
            out_valid_nxt = 1'b1;
          end else if ((status_r == atrm_pkg::ST_RUN) && !(timeout_r > tick_sat)) begin
            elapsed_nxt = '0;
            if (var_r) begin
              status_nxt    = atrm_pkg::ST_OK;
              busy_nxt      = 1'b0;
              cap_nxt       = '0;
              ev.event_res  = atrm_pkg::EV_CAPTURE;
              ev.line_count = cap_r;
            end else begin
              status_nxt       = atrm_pkg::ST_FAIL;
              busy_nxt         = crit_r;
              ev.event_res     = atrm_pkg::EV_TIMEOUT;
              ev.match_index   = 3'(atrm_pkg::NUM_ERR);
              ev.critical_flag = crit_r;
              ev.timeout_flag  = 1'b1;
              ev.busy_res      = crit_r;
            end
            out_nxt       = ev;
            out_valid_nxt = 1'b1;
          end
        end
        atrm_pkg::CMD_RESEND: status_nxt = atrm_pkg::ST_REPEAT;
        atrm_pkg::CMD_READ:   slot_nxt   = {1'b0, in_data.slot};
        default: ;
      endcase
    end

    // scan and copy counters
    if (ctl.scan_init) begin
      slot_nxt  = '0;
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (ctl.skip_slot) begin
      slot_nxt = slot_r + 1'b1;
      idx_nxt  = '0;
    end
    if (ctl.step_idx) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (ctl.set_found) begin
      found_nxt = 1'b1;
    end

    // line end outcome
    if (ctl.finish) begin
      ev.line_overflow = line_ovf_r;
      if (var_r) begin
        slot_len_nxt[cap_slot] = line_len_r;
        if (cap_inc >= atrm_pkg::CNT_W'(atrm_pkg::NUM_SLOTS)) begin
          cap_nxt       = '0;
          ev.event_res  = atrm_pkg::EV_CAPTURE;
          ev.line_count = cap_inc;
          ev.busy_res   = busy_r;
          out_nxt       = ev;
          out_valid_nxt = 1'b1;
        end else begin
          cap_nxt = cap_inc;
        end
      end else if (found_r) begin
        if (slot_r < atrm_pkg::SCAN_W'(atrm_pkg::NUM_RSP)) begin
          busy_nxt       = 1'b0;
          status_nxt     = atrm_pkg::ST_OK;
          ev.event_res   = atrm_pkg::EV_MATCH;
          ev.match_index = slot_r[2:0];
          out_nxt        = ev;
          out_valid_nxt  = 1'b1;
        end else if (crit_r) begin
          busy_nxt   = 1'b1;
          status_nxt = atrm_pkg::ST_REPEAT;
        end else begin
          busy_nxt       = 1'b0;
          status_nxt     = atrm_pkg::ST_FAIL;
          ev.event_res   = atrm_pkg::EV_ERROR;
          ev.match_index = 3'(slot_r - atrm_pkg::SCAN_W'(atrm_pkg::NUM_RSP));
          out_nxt        = ev;
          out_valid_nxt  = 1'b1;
        end
      end
      line_len_nxt = '0;
      ovf_nxt      = 1'b0;
    end

    // capture read result
    if (ctl.read_emit) begin
      ev.event_res  = atrm_pkg::EV_READ;
      ev.read_byte  = pat_q;
      ev.read_len   = cur_slot_len;
      ev.busy_res   = busy_r;
      out_nxt       = ev;
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= '0;
      crit_r      <= 1'b0;
      var_r       <= 1'b0;
      status_r    <= atrm_pkg::ST_FAIL;
      busy_r      <= 1'b0;
      elapsed_r   <= '0;
      prev_r      <= '0;
      line_len_r  <= '0;
      slot_len_r  <= '{default: '0};
      cap_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      crit_r      <= crit_nxt;
      var_r       <= var_nxt;
      status_r    <= status_nxt;
      busy_r      <= busy_nxt;
      elapsed_r   <= elapsed_nxt;
      prev_r      <= prev_nxt;
      line_len_r  <= line_len_nxt;
      slot_len_r  <= slot_len_nxt;
      cap_r       <= cap_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    line_ovf_r <= line_ovf_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/atrm_checker.sv =====
// Port-level checks for the AT response matcher, bound to the top level.
// Depends on atrm_pkg.
`default_nettype none
module atrm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire atrm_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire atrm_pkg::out_word_t out_data
);

  // a pending word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a start answers with a send request and busy set
  a_start_send: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == atrm_pkg::CMD_START) |=>
      out_valid && (out_data.event_res == atrm_pkg::EV_SEND) && out_data.busy_res)
    else $error("start without send request");

  // an offered word always carries an event
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_res != atrm_pkg::EV_NONE))
    else $error("result word without event");

  // match or error reply ends the command
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.event_res == atrm_pkg::EV_MATCH) ||
                  (out_data.event_res == atrm_pkg::EV_ERROR)) |-> !out_data.busy_res)
    else $error("busy after final reply");

endmodule

bind at_response_matcher_unit atrm_checker u_atrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
